// ===== sv/pidc_pkg.sv =====
// pidc_pkg: shared types and constants of the pid controller step block
// used by pidc_ctrl, pidc_dp and pid_controller_step; depends on nothing
`default_nettype none
package pidc_pkg;

  // field widths
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned DIFF_W  = 18;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned BND_W   = 25;
  localparam int unsigned MULB_W  = 24;
  localparam int unsigned PROD_W  = 41;
  localparam int unsigned ACC_W   = 42;
  localparam int unsigned IDX_W   = 3;

  // restoring divider for the integral bounds
  localparam int unsigned DIV_STEPS = 24;
  localparam int unsigned DCNT_W    = 5;

  // register indexes
  localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DRIVE_MAX = 3'd3;
  localparam logic [IDX_W-1:0] REG_DRIVE_MIN = 3'd4;

  localparam logic signed [VAL_W-1:0] DRIVE_MAX_RST = 16'sh7FFF;
  localparam logic signed [VAL_W-1:0] DRIVE_MIN_RST = 16'sh8000;

  // multiplier operand select
  localparam logic [1:0] MUL_P = 2'd0;
  localparam logic [1:0] MUL_I = 2'd1;
  localparam logic [1:0] MUL_D = 2'd2;

  // bound select for the divider
  localparam logic BND_HI = 1'b0;
  localparam logic BND_LO = 1'b1;

  typedef struct packed {
    logic       load;      // take a word, shift the error history
    logic       div_init;
    logic       div_step;
    logic       div_last;
    logic       div_sel;
    logic       integ;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_clr;
    logic       acc_add;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic stale;           // integral bounds need recomputing
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/pidc_ctrl.sv =====
// pidc_ctrl: sequencer of the pid controller step
// drives pidc_dp through dp_cmd_t; uses pidc_pkg
`default_nettype none
module pidc_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  pidc_pkg::dp_stat_t  stat,
  output pidc_pkg::dp_cmd_t   cmd
);
  import pidc_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DINIT_H = 4'd1;
  localparam logic [3:0] S_DRUN_H  = 4'd2;
  localparam logic [3:0] S_DINIT_L = 4'd3;
  localparam logic [3:0] S_DRUN_L  = 4'd4;
  localparam logic [3:0] S_INTEG   = 4'd5;
  localparam logic [3:0] S_MUL_P   = 4'd6;
  localparam logic [3:0] S_MUL_I   = 4'd7;
  localparam logic [3:0] S_MUL_D   = 4'd8;
  localparam logic [3:0] S_SUM     = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  localparam logic [DCNT_W-1:0] CNT_LAST = DCNT_W'(DIV_STEPS - 1);

  logic [3:0]        state, state_next;
  logic [DCNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.stale ? S_DINIT_H : S_INTEG;
        end
      end
      S_DINIT_H: begin
        cmd.div_init = 1'b1;
        cmd.div_sel  = BND_HI;
        cnt_next     = '0;
        state_next   = S_DRUN_H;
      end
      S_DRUN_H: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = BND_HI;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          cmd.div_last = 1'b1;
          state_next   = S_DINIT_L;
        end
      end
      S_DINIT_L: begin
        cmd.div_init = 1'b1;
        cmd.div_sel  = BND_LO;
        cnt_next     = '0;
        state_next   = S_DRUN_L;
      end
      S_DRUN_L: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = BND_LO;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          cmd.div_last = 1'b1;
          state_next   = S_INTEG;
        end
      end
      S_INTEG: begin
        cmd.integ  = 1'b1;
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
        cmd.acc_clr = 1'b1;
        state_next  = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_I;
        cmd.acc_add = 1'b1;
        state_next  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
        cmd.acc_add = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.acc_add = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/pidc_dp.sv =====
// pidc_dp: datapath of the pid controller step: registers, error history,
// bound divider, shared multiplier, accumulator and output register; uses pidc_pkg
`default_nettype none
module pidc_dp (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_wr_en,
  input  wire [pidc_pkg::IDX_W-1:0]             cfg_index,
  input  wire [pidc_pkg::VAL_W-1:0]             cfg_data,
  input  wire signed [pidc_pkg::VAL_W-1:0]      setpoint,
  input  wire signed [pidc_pkg::VAL_W-1:0]      measured,
  input  wire                                   out_ready,
  output logic                                  out_valid,
  output logic signed [pidc_pkg::VAL_W-1:0]     drive,
  input  pidc_pkg::dp_cmd_t                     cmd,
  output pidc_pkg::dp_stat_t                    stat
);
  import pidc_pkg::*;

  logic [GAIN_W-1:0]        gain_p, gain_i, gain_d;
  logic signed [VAL_W-1:0]  drive_max, drive_min;
  logic                     stale;

  logic signed [ERR_W-1:0]  err_now, err_prev;
  logic signed [SUM_W-1:0]  err_sum;
  logic signed [BND_W-1:0]  bnd_hi, bnd_lo;

  // divider: quotient shifts into the dividend register
  logic [GAIN_W-1:0]        rem;
  logic [SUM_W-1:0]         nq;
  logic                     div_neg;
  logic signed [VAL_W-1:0]  div_x;
  logic signed [ERR_W-1:0]  div_xe, div_mag;
  logic [GAIN_W:0]          trial;
  logic                     ge;
  logic [SUM_W-1:0]         quo_fin;
  logic signed [BND_W-1:0]  quo_s, bound;

  logic signed [BND_W-1:0]  int_acc, int_clamp;

  logic signed [GAIN_W:0]   mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_s;
  logic signed [DIFF_W-1:0] diff;

  logic signed [ACC_W-9:0]  q, qc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= '0;
      gain_i    <= '0;
      gain_d    <= '0;
      drive_max <= DRIVE_MAX_RST;
      drive_min <= DRIVE_MIN_RST;
      stale     <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GAIN_P:    gain_p <= cfg_data;
          REG_GAIN_I: begin
            gain_i <= cfg_data;
            stale  <= 1'b1;
          end
          REG_GAIN_D:    gain_d <= cfg_data;
          REG_DRIVE_MAX: begin
            drive_max <= $signed(cfg_data);
            stale     <= 1'b1;
          end
          REG_DRIVE_MIN: begin
            drive_min <= $signed(cfg_data);
            stale     <= 1'b1;
          end
          default: ;
        endcase
      end else if (cmd.div_last && cmd.div_sel == BND_LO) begin
        stale <= 1'b0;
      end
    end
  end

  // error history
  always_ff @(posedge clk) begin
    if (rst) begin
      err_now  <= '0;
      err_prev <= '0;
    end else if (cmd.load) begin
      err_prev <= err_now;
      err_now  <= ERR_W'(setpoint) - ERR_W'(measured);
    end
  end

  // bound divider: |limit| * 256 / gain_i, truncated toward zero, with the limit's sign put back
  always_comb begin
    div_x   = (cmd.div_sel == BND_LO) ? drive_min : drive_max;
    div_xe  = ERR_W'(div_x);
    div_mag = div_xe[ERR_W-1] ? -div_xe : div_xe;
    trial   = {rem, nq[SUM_W-1]};
    ge      = (trial >= {1'b0, gain_i});
    quo_fin = {nq[SUM_W-2:0], ge};
    quo_s   = $signed({1'b0, quo_fin});
    bound   = div_neg ? -quo_s : quo_s;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= '0;
      nq      <= {div_mag[VAL_W-1:0], 8'd0};
      div_neg <= div_x[VAL_W-1];
    end else if (cmd.div_step) begin
      rem <= ge ? GAIN_W'(trial - {1'b0, gain_i}) : trial[GAIN_W-1:0];
      nq  <= quo_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && cmd.div_last) begin
      if (cmd.div_sel == BND_LO) begin
        bnd_lo <= bound;
      end else begin
        bnd_hi <= bound;
      end
    end
  end

  // integral with clamp, upper first so the lower limit wins
  always_comb begin
    int_acc   = BND_W'(err_sum) + BND_W'(err_now);
    int_clamp = int_acc;
    if (int_clamp > bnd_hi) int_clamp = bnd_hi;
    if (int_clamp < bnd_lo) int_clamp = bnd_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_sum <= '0;
    end else if (cmd.integ) begin
      err_sum <= (gain_i == '0) ? '0 : int_clamp[SUM_W-1:0];
    end
  end

  // shared multiplier
  always_comb begin
    diff = DIFF_W'(err_now) - DIFF_W'(err_prev);
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = $signed({1'b0, gain_p});
        mul_b = MULB_W'(err_now);
      end
      MUL_I: begin
        mul_a = $signed({1'b0, gain_i});
        mul_b = err_sum;
      end
      MUL_D: begin
        mul_a = $signed({1'b0, gain_d});
        mul_b = MULB_W'(diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // operands sign extended to the full product width
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_s <= '0;
    end else if (cmd.acc_add) begin
      acc_s <= acc_s + ACC_W'(prod);
    end
  end

  // floor shift by 8 and output clamp
  always_comb begin
    q  = acc_s[ACC_W-1:8];
    qc = q;
    if (qc > (ACC_W-8)'(drive_max)) qc = (ACC_W-8)'(drive_max);
    if (qc < (ACC_W-8)'(drive_min)) qc = (ACC_W-8)'(drive_min);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      drive <= qc[VAL_W-1:0];
    end
  end

  assign stat.stale    = stale;
  assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== sv/pid_controller_step.sv =====
// pid_controller_step: top level of the positional pid step with integral clamp
// joins pidc_ctrl and pidc_dp; uses pidc_pkg
//
//   channel   signals                              direction
//   config    cfg_wr_en cfg_index cfg_data         write only
//   input     in_valid in_ready setpoint measured  word in
//   output    out_valid out_ready drive            word out
//
// one word at a time: after accept the sequencer steps through integ, mul_p, mul_i, mul_d, sum
// and fin, loading the result register in fin. after reset or a write to gain_i, drive_max or
// drive_min the next word also runs the integral bound divider, a restoring divider doing 1 bit
// a cycle, for the upper and then the lower bound. the three products go through one shared
// 17x24 multiplier, one per cycle. reset is synchronous; a result held by out_ready low blocks
// the next word only at its final step, and in_ready is high only while the sequencer is idle.
`default_nettype none
module pid_controller_step (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire [pidc_pkg::IDX_W-1:0]         cfg_index,
  input  wire [pidc_pkg::VAL_W-1:0]         cfg_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire signed [pidc_pkg::VAL_W-1:0]  setpoint,
  input  wire signed [pidc_pkg::VAL_W-1:0]  measured,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [pidc_pkg::VAL_W-1:0] drive
);
  import pidc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pidc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pidc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .setpoint  (setpoint),
    .measured  (measured),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .drive     (drive),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

// ===== tb/pid_controller_step_tb.sv =====
// pid_controller_step_tb: self-checking testbench of the positional pid step block
// drives config writes and setpoint/measured words with random idling on both channels,
// predicts each drive value in a small scoreboard class; depends on pidc_pkg and the rtl
`default_nettype none
module pid_controller_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PHASES = 20;

  // predicts drive values from accepted words and checks them in order
  class drive_scoreboard;
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic signed [15:0] drive_max;
    logic signed [15:0] drive_min;
    logic signed [16:0] err_now;
    logic signed [16:0] err_prev;
    logic signed [31:0] err_sum;
    logic signed [15:0] drive_q[$];
    int                 errors;
    int                 checked;

    function new();
      gain_p    = '0;
      gain_i    = '0;
      gain_d    = '0;
      drive_max = DRIVE_MAX_RST;
      drive_min = DRIVE_MIN_RST;
      err_now   = '0;
      err_prev  = '0;
      err_sum   = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        REG_GAIN_P:    gain_p = data;
        REG_GAIN_I:    gain_i = data;
        REG_GAIN_D:    gain_d = data;
        REG_DRIVE_MAX: drive_max = data;
        REG_DRIVE_MIN: drive_min = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return drive_q.size();
    endfunction

    function void add_step(logic signed [15:0] sp, logic signed [15:0] ms);
      longint e;
      longint acc;
      longint hi;
      longint lo;
      longint s;
      longint q;
      e = longint'(sp) - longint'(ms);
      err_prev = err_now;
      err_now = e[16:0];
      if (gain_i != 0) begin
        acc = longint'(err_sum) + e;
        // bounds truncate toward zero; upper first so a crossed lower limit wins
        hi = (longint'(drive_max) * 256) / longint'(gain_i);
        lo = (longint'(drive_min) * 256) / longint'(gain_i);
        if (acc > hi) acc = hi;
        if (acc < lo) acc = lo;
        err_sum = acc[31:0];
      end else begin
        err_sum = '0;
      end
      s = longint'(gain_p) * e
        + longint'(gain_i) * longint'(err_sum)
        + longint'(gain_d) * (e - longint'(err_prev));
      q = s >>> 8;
      if (q > longint'(drive_max)) q = longint'(drive_max);
      if (q < longint'(drive_min)) q = longint'(drive_min);
      drive_q.push_back(q[15:0]);
    endfunction

    function void check_drive(logic signed [15:0] actual);
      logic signed [15:0] want;
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected drive word, actual %0d", $time, actual);
        errors++;
      end else begin
        want = drive_q.pop_front();
        checked++;
        if (actual !== want) begin
          $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [VAL_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] setpoint = '0;
  logic signed [15:0] measured = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] drive;

  drive_scoreboard sb;
  int  cycle_count = 0;
  int  word_count = 0;
  int  reg_writes = 0;
  int  setting_count = 0;
  int  ready_left = 0;
  bit  src_free = 1'b0;
  bit  sink_free = 1'b0;

  pid_controller_step u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .setpoint  (setpoint),
    .measured  (measured),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d drive words outstanding", $time, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // mostly short idle stretches, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // receiver side back-pressure
  always @(negedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
    end else if (sink_free || !out_ready) begin
      out_ready <= 1'b1;
      ready_left = sink_free ? 0 : $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b0;
      ready_left = idle_len() - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_drive(drive);
  end

  task automatic send_word(input logic signed [15:0] sp, input logic signed [15:0] ms);
    int gap;
    gap = (src_free || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    setpoint <= sp;
    measured <= ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.add_step(sp, ms);
    word_count++;
  endtask

  // drop valid and hold off until every drive word has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    reg_writes++;
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    setting_count++;
  endtask

  function automatic logic [15:0] rand_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 25) return 16'hFFFF;
    if (r < 30) return 16'd1;
    if (r < 60) return 16'($urandom_range(1, 512));
    if (r < 85) return 16'($urandom_range(0, 2048));
    return 16'($urandom);
  endfunction

  task automatic rand_settings();
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      hi = DRIVE_MAX_RST;
      lo = DRIVE_MIN_RST;
    end else if (r < 50) begin
      hi = 16'($urandom_range(0, 2000));
      lo = -16'($urandom_range(0, 2000));
    end else if (r < 60) begin
      // limits crossed
      hi = DRIVE_MIN_RST;
      lo = DRIVE_MAX_RST;
    end else begin
      hi = 16'($urandom);
      lo = 16'($urandom);
    end
    cfg_write(REG_GAIN_P, rand_gain());
    cfg_write(REG_GAIN_I, rand_gain());
    cfg_write(REG_GAIN_D, rand_gain());
    cfg_write(REG_DRIVE_MAX, hi);
    cfg_write(REG_DRIVE_MIN, lo);
    cfg_done();
  endtask

  initial begin
    logic signed [15:0] sp;
    logic signed [15:0] ms;
    logic signed [15:0] bias;
    logic signed [15:0] corner[4];
    int n_items;
    int r;
    sb = new();
    corner[0] = 16'sh7FFF;
    corner[1] = 16'sh8000;
    corner[2] = 16'sh0000;
    corner[3] = 16'shFFFF;

    sink_free = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: all gains zero
    send_word(16'sd1000, -16'sd1000);
    send_word(16'sh8000, 16'sh7FFF);
    drain();

    cfg_write(REG_GAIN_P, 16'd256);
    cfg_write(REG_GAIN_I, 16'd256);
    cfg_write(REG_GAIN_D, 16'd256);
    cfg_done();
    send_word(16'sh7FFF, 16'sh8000);
    send_word(16'sh8000, 16'sh7FFF);
    send_word(16'sd0, 16'sd0);
    send_word(16'sh7FFF, 16'sh7FFF);
    send_word(16'sh8000, 16'sh8000);
    send_word(16'sd1, 16'sd0);
    send_word(-16'sd1, 16'sd0);
    send_word(16'sd0, 16'sd1);
    drain();

    // integral runs into its clamp
    cfg_write(REG_GAIN_P, 16'd0);
    cfg_write(REG_GAIN_D, 16'd0);
    cfg_write(REG_GAIN_I, 16'd1);
    cfg_write(REG_DRIVE_MAX, 16'sd100);
    cfg_write(REG_DRIVE_MIN, -16'sd100);
    cfg_done();
    repeat (4) send_word(16'sh7FFF, 16'sh8000);
    repeat (2) send_word(16'sh8000, 16'sh7FFF);
    drain();

    cfg_write(REG_GAIN_P, 16'hFFFF);
    cfg_write(REG_GAIN_I, 16'hFFFF);
    cfg_write(REG_GAIN_D, 16'hFFFF);
    cfg_write(REG_DRIVE_MAX, DRIVE_MAX_RST);
    cfg_write(REG_DRIVE_MIN, DRIVE_MIN_RST);
    cfg_done();
    send_word(16'sh7FFF, 16'sh8000);
    send_word(16'sh8000, 16'sh7FFF);
    send_word(16'sd5, 16'sd0);
    drain();

    // crossed limits, lower one wins
    cfg_write(REG_DRIVE_MAX, -16'sd100);
    cfg_write(REG_DRIVE_MIN, 16'sd100);
    cfg_done();
    send_word(16'sd0, 16'sd0);
    send_word(16'sd20000, 16'sd0);
    send_word(-16'sd20000, 16'sd0);
    drain();

    // zero integral gain clears the sum
    cfg_write(REG_GAIN_I, 16'd0);
    cfg_done();
    send_word(16'sd100, 16'sd0);
    send_word(16'sd0, 16'sd100);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      rand_settings();
      src_free  = ($urandom_range(0, 4) == 0);
      sink_free = ($urandom_range(0, 4) == 0);
      bias = 16'($urandom_range(0, 8000)) - 16'sd4000;
      n_items = $urandom_range(45, 80);
      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        sp = 16'($urandom);
        if (r < 45) begin
          ms = 16'($urandom);
        end else if (r < 75) begin
          ms = sp + 16'($urandom_range(0, 128)) - 16'sd64;
        end else if (r < 92) begin
          // sustained error of one sign pushes the integral to its bound
          ms = sp - bias;
        end else begin
          sp = corner[$urandom_range(0, 3)];
          ms = corner[$urandom_range(0, 3)];
        end
        send_word(sp, ms);
        if ((ph == 3 && i == 20) || $urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d words over %0d settings with %0d register writes",
             word_count, setting_count, reg_writes);
    $display("checked %0d drive words, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
